// File: sv/pga_pkg.sv
package pga_pkg;

  localparam int COORD_IN_W        = 24;
  localparam int COORD_BITS        = 24;
  localparam int MAX_RING_VERTICES = 65536;
  localparam int PROD_W            = 2 * COORD_BITS;
  localparam int SUM_W             = 64;
  localparam int CNT_W             = $clog2(MAX_RING_VERTICES + 2);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic        [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic valid;
    logic open_term;
    logic close;
    logic hole;
    logic enough;
    logic send;
    logic ovf;
  } pga_flags_t;

endpackage

// File: sv/pga_vertex_if.sv
interface pga_vertex_if import pga_pkg::*; (
  input logic clk
);
  logic                  valid;
  logic                  ready;
  logic [COORD_IN_W-1:0] x_coord;
  logic [COORD_IN_W-1:0] y_coord;
  logic                  is_hole;
  logic                  ring_end;
  logic                  surface_end;

  modport source (
    output valid, x_coord, y_coord, is_hole, ring_end, surface_end,
    input  ready
  );
  modport sink (
    input  valid, x_coord, y_coord, is_hole, ring_end, surface_end,
    output ready
  );
endinterface

// File: sv/pga_area_if.sv
interface pga_area_if import pga_pkg::*; (
  input logic clk
);
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] twice_area;
  logic             overflow;

  modport source (
    output valid, twice_area, overflow,
    input  ready
  );
  modport sink (
    input  valid, twice_area, overflow,
    output ready
  );
endinterface

// File: sv/pga_front.sv
module pga_front import pga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  pga_vertex_if.sink vertex,
  output prod_t      pa,
  output prod_t      pb,
  output prod_t      pc,
  output prod_t      pd,
  output pga_flags_t flags
);

  localparam cnt_t CNT_MAX = cnt_t'(MAX_RING_VERTICES);

  coord_t first_x;
  coord_t first_y;
  coord_t prev_x;
  coord_t prev_y;
  cnt_t   count;
  logic   overflow_seen;

  coord_t     x;
  coord_t     y;
  coord_t     fx;
  coord_t     fy;
  cnt_t       cnt_inc;
  logic       closing;
  logic       ovf_now;
  logic       accept;
  pga_flags_t flags_next;

  assign vertex.ready = adv;
  assign accept       = vertex.valid && adv;

  assign x       = $signed(vertex.x_coord[COORD_BITS-1:0]);
  assign y       = $signed(vertex.y_coord[COORD_BITS-1:0]);
  assign fx      = (count == '0) ? x : first_x;
  assign fy      = (count == '0) ? y : first_y;
  assign cnt_inc = (count <= CNT_MAX) ? cnt_t'(count + 1'b1) : count;
  assign closing = vertex.ring_end || vertex.surface_end;
  assign ovf_now = overflow_seen || (cnt_inc > CNT_MAX);

  always_comb begin
    flags_next.valid     = vertex.valid;
    flags_next.open_term = (count != '0);
    flags_next.close     = closing;
    flags_next.hole      = vertex.is_hole;
    flags_next.enough    = (cnt_inc >= cnt_t'(2));
    flags_next.send      = vertex.surface_end;
    flags_next.ovf       = ovf_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x       <= '0;
      first_y       <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      count         <= '0;
      overflow_seen <= 1'b0;
      flags         <= '0;
    end else if (adv) begin
      flags <= flags_next;
      if (accept) begin
        first_x       <= fx;
        first_y       <= fy;
        prev_x        <= x;
        prev_y        <= y;
        count         <= closing ? '0 : cnt_inc;
        overflow_seen <= vertex.surface_end ? 1'b0 : ovf_now;
      end
    end
  end

  // Cross terms: previous edge into this vertex, and the closing edge back to the first.
  always_ff @(posedge clk) begin
    if (adv) begin
      pa <= prev_x * y;
      pb <= prev_y * x;
      pc <= x * fy;
      pd <= y * fx;
    end
  end

endmodule

// File: sv/pga_ring.sv
module pga_ring import pga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  prod_t      pa,
  input  prod_t      pb,
  input  prod_t      pc,
  input  prod_t      pd,
  input  pga_flags_t fin,
  output sum_t       ring_abs,
  output pga_flags_t fout
);

  pga_flags_t fl_b;
  pga_flags_t fl_c;
  sum_t       delta;
  sum_t       ring_sum;
  sum_t       closed;

  sum_t d1;
  sum_t d2;
  sum_t ring_next;

  assign d1        = fin.open_term ? sum_t'(sum_t'(pa) - sum_t'(pb)) : '0;
  assign d2        = fin.close ? sum_t'(sum_t'(pc) - sum_t'(pd)) : '0;
  assign ring_next = sum_t'(ring_sum + delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      fl_b     <= '0;
      fl_c     <= '0;
      fout     <= '0;
      ring_sum <= '0;
    end else if (adv) begin
      fl_b <= fin;
      fl_c <= fl_b;
      fout <= fl_c;
      if (fl_b.valid) begin
        ring_sum <= fl_b.close ? '0 : ring_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      delta    <= sum_t'(d1 + d2);
      closed   <= ring_next;
      ring_abs <= closed[SUM_W-1] ? sum_t'(-closed) : closed;
    end
  end

endmodule

// File: sv/pga_total.sv
module pga_total import pga_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       adv,
  input  pga_flags_t fin,
  input  sum_t       ring_abs,
  pga_area_if.source area
);

  sum_t total;
  logic bvalid;

  sum_t tot_next;
  logic bvalid_next;

  always_comb begin
    tot_next    = total;
    bvalid_next = bvalid;
    if (fin.close) begin
      if (!fin.hole) begin
        bvalid_next = fin.enough;
        tot_next    = fin.enough ? ring_abs : '0;
      end else if (fin.enough && bvalid) begin
        tot_next = sum_t'(total - ring_abs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      bvalid     <= 1'b0;
      area.valid <= 1'b0;
    end else if (adv) begin
      area.valid <= fin.valid && fin.send;
      if (fin.valid) begin
        if (fin.send) begin
          total  <= '0;
          bvalid <= 1'b0;
        end else begin
          total  <= tot_next;
          bvalid <= bvalid_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin.valid && fin.send) begin
      area.twice_area <= bvalid_next ? tot_next : '0;
      area.overflow   <= fin.ovf;
    end
  end

endmodule

// File: sv/polygon_area_with_holes.sv
// Channel  Dir  Word
// vertex   in   x_coord, y_coord, is_hole, ring_end, surface_end
// area     out  twice_area, overflow (one word per surface_end vertex)
//
// One vertex word is taken every cycle unless an area word waits for ready. A surface
// result is registered through the multiply stage, the ring accumulator and the absolute
// value ahead of the surface total. Reset is synchronous and clears all control
// state. While an area word waits for ready, every stage holds and vertex.ready is low.
module polygon_area_with_holes import pga_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pga_vertex_if.sink   vertex,
  pga_area_if.source   area
);

  logic       adv;
  prod_t      pa;
  prod_t      pb;
  prod_t      pc;
  prod_t      pd;
  pga_flags_t front_flags;
  pga_flags_t ring_flags;
  sum_t       ring_abs;

  assign adv = !(area.valid && !area.ready);

  pga_front u_front (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .vertex (vertex),
    .pa     (pa),
    .pb     (pb),
    .pc     (pc),
    .pd     (pd),
    .flags  (front_flags)
  );

  pga_ring u_ring (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .pa       (pa),
    .pb       (pb),
    .pc       (pc),
    .pd       (pd),
    .fin      (front_flags),
    .ring_abs (ring_abs),
    .fout     (ring_flags)
  );

  pga_total u_total (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .fin      (ring_flags),
    .ring_abs (ring_abs),
    .area     (area)
  );

  a_result_from_send: assert property (@(posedge clk) disable iff (rst)
    adv |=> (area.valid == $past(ring_flags.valid && ring_flags.send)))
    else $error("area word does not match the surface end in the pipeline");

  a_send_closes: assert property (@(posedge clk) disable iff (rst)
    (front_flags.valid && front_flags.send) |-> front_flags.close)
    else $error("surface end left a ring open");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(front_flags) && $stable(ring_flags)))
    else $error("pipeline moved during a stall");

endmodule
